/* design/nbba_pkg.sv */
package nbba_pkg;

    // Command codes carried in the func field.
    localparam logic [2:0] FUNC_INIT    = 3'd0;
    localparam logic [2:0] FUNC_ERASE   = 3'd1;
    localparam logic [2:0] FUNC_PROGRAM = 3'd2;
    localparam logic [2:0] FUNC_READ    = 3'd3;
    localparam logic [2:0] FUNC_MARK    = 3'd4;

    // Result status codes.
    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_BAD        = 3'd1;
    localparam logic [2:0] STAT_NO_GOOD    = 3'd2;
    localparam logic [2:0] STAT_NOT_ERASED = 3'd3;
    localparam logic [2:0] STAT_INVALID    = 3'd4;

    // Reset value of the factory bad-block mask.
    localparam logic [3:0] FACTORY_MASK_RESET = 4'b0010;

    typedef struct packed {
        logic [2:0]  func;
        logic [1:0]  block_index;
        logic [1:0]  wordline_index;
        logic [31:0] cell_values;
    } nbba_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        redirected;
        logic [1:0]  target_block;
        logic [31:0] read_data;
    } nbba_out_t;

    // Array operation chosen for an accepted command.
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_INIT,
        ACT_ERASE,
        ACT_PROGRAM,
        ACT_READ,
        ACT_MARK
    } act_t;

    typedef struct packed {
        act_t       act;
        logic [2:0] status;
        logic       redirected;
        logic [1:0] target_block;
    } nbba_dec_t;

endpackage

/* design/nbba_ram.sv */
module nbba_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* design/nbba_check.sv */
module nbba_check #(
    parameter int NUM_BLOCKS         = 4,
    parameter int NUM_WORDLINES      = 4,
    parameter int CELLS_PER_WORDLINE = 8,
    parameter int BLK_W              = 2,
    parameter int WL_W               = 2,
    parameter int ADDR_W             = 4
) (
    input  nbba_pkg::nbba_in_t    cmd,
    input  logic [NUM_BLOCKS-1:0] bad_flags,
    input  logic [NUM_BLOCKS-1:0] erased_flags,
    output nbba_pkg::nbba_dec_t   dec,
    output logic [BLK_W-1:0]      tgt_blk,
    output logic [ADDR_W-1:0]     mem_addr
);
    import nbba_pkg::*;

    localparam int CHECK_CELLS = (CELLS_PER_WORDLINE < 8) ? CELLS_PER_WORDLINE : 8;

    logic [31:0]      msb_mask;
    logic             blk_ok;
    logic             wl_ok;
    logic [BLK_W-1:0] blk_idx;
    logic [WL_W-1:0]  wl_idx;
    logic             blk_bad;
    logic             any_good;
    logic [BLK_W-1:0] first_good;
    logic             value_bad;

    // The top bit of every checked nibble; a set bit means a value above 7.
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            msb_mask[4*k +: 4] = (k < CHECK_CELLS) ? 4'b1000 : 4'b0000;
        end
    end

    assign blk_ok    = int'(cmd.block_index) < NUM_BLOCKS;
    assign wl_ok     = int'(cmd.wordline_index) < NUM_WORDLINES;
    assign blk_idx   = BLK_W'(cmd.block_index);
    assign wl_idx    = WL_W'(cmd.wordline_index);
    assign blk_bad   = !blk_ok || bad_flags[blk_idx];
    assign value_bad = |(cmd.cell_values & msb_mask);

    // Priority encoder for the lowest good block.
    always_comb begin
        any_good   = 1'b0;
        first_good = '0;
        for (int b = NUM_BLOCKS - 1; b >= 0; b--) begin
            if (!bad_flags[b]) begin
                any_good   = 1'b1;
                first_good = BLK_W'(b);
            end
        end
    end

    always_comb begin
        dec.act          = ACT_NONE;
        dec.status       = STAT_OK;
        dec.redirected   = 1'b0;
        dec.target_block = cmd.block_index;
        tgt_blk          = blk_idx;
        case (cmd.func)
            FUNC_INIT: begin
                dec.act          = ACT_INIT;
                dec.target_block = 2'd0;
            end
            FUNC_ERASE: begin
                if (blk_bad) begin
                    dec.status = STAT_BAD;
                end else begin
                    dec.act = ACT_ERASE;
                end
            end
            FUNC_PROGRAM: begin
                if (!wl_ok) begin
                    dec.status = STAT_INVALID;
                end else if (blk_bad && !any_good) begin
                    dec.status = STAT_NO_GOOD;
                end else begin
                    if (blk_bad) begin
                        dec.redirected   = 1'b1;
                        dec.target_block = 2'(first_good);
                        tgt_blk          = first_good;
                    end
                    if (!erased_flags[tgt_blk]) begin
                        dec.status = STAT_NOT_ERASED;
                    end else if (value_bad) begin
                        dec.status = STAT_INVALID;
                    end else begin
                        dec.act = ACT_PROGRAM;
                    end
                end
            end
            FUNC_READ: begin
                if (!wl_ok) begin
                    dec.status = STAT_INVALID;
                end else if (blk_bad) begin
                    dec.status = STAT_BAD;
                end else begin
                    dec.act = ACT_READ;
                end
            end
            FUNC_MARK: begin
                if (blk_ok) begin
                    dec.act = ACT_MARK;
                end
            end
            default: begin
                dec.status = STAT_INVALID;
            end
        endcase
    end

    assign mem_addr = ADDR_W'(tgt_blk * NUM_WORDLINES + wl_idx);

endmodule

/* design/nand_bad_block_array.sv */
// Channel   Ports                          Direction  Payload
// input     s_valid / s_ready / s_data     in         nbba_in_t command beat
// result    m_valid / m_ready / m_data     out        nbba_out_t result beat
// config    cfg_valid / cfg_ready / cfg_data  in      4-bit factory bad-block mask
//
// One command is in work at a time; s_ready is high only while the sequencer idles.
// From accept to next accept, mark bad, refused commands and program pass S_EXEC, S_DONE;
// read adds S_RDWAIT, erase and init add S_SWEEP over the wordlines of the block or of all
// blocks, driven by the one memory write port, which sweeps one wordline a cycle. Reset
// starts a clearing pass of all memory. A result waits in the sequencer while the output
// register is full and not being taken; the next command is accepted once it has moved there.
module nand_bad_block_array #(
    parameter int NUM_BLOCKS         = 4,
    parameter int NUM_WORDLINES      = 4,
    parameter int CELLS_PER_WORDLINE = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  nbba_pkg::nbba_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output nbba_pkg::nbba_out_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_data
);
    import nbba_pkg::*;

    localparam int DEPTH   = NUM_BLOCKS * NUM_WORDLINES;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BLK_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int WL_W    = (NUM_WORDLINES > 1) ? $clog2(NUM_WORDLINES) : 1;
    localparam int WL_BITS = 4 * ((CELLS_PER_WORDLINE < 8) ? CELLS_PER_WORDLINE : 8);
    localparam logic [WL_BITS-1:0] ERASED_WORD = {WL_BITS{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_RDWAIT,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    nbba_in_t              cmd_reg, cmd_next;
    nbba_out_t             res_reg, res_next;
    nbba_out_t             out_reg, out_next;
    logic                  m_valid_reg, m_valid_next;
    logic [NUM_BLOCKS-1:0] bad_reg, bad_next;
    logic [NUM_BLOCKS-1:0] erased_reg, erased_next;
    logic [3:0]            mask_reg, mask_next;
    logic [ADDR_W-1:0]     sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0]     sweep_last_reg, sweep_last_next;
    logic                  sweep_resp_reg, sweep_resp_next;

    nbba_dec_t             dec;
    logic [BLK_W-1:0]      tgt_blk;
    logic [ADDR_W-1:0]     cmd_addr;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_addr;
    logic [WL_BITS-1:0]    ram_wdata;
    logic [WL_BITS-1:0]    ram_rdata;

    nbba_check #(
        .NUM_BLOCKS         (NUM_BLOCKS),
        .NUM_WORDLINES      (NUM_WORDLINES),
        .CELLS_PER_WORDLINE (CELLS_PER_WORDLINE),
        .BLK_W              (BLK_W),
        .WL_W               (WL_W),
        .ADDR_W             (ADDR_W)
    ) u_check (
        .cmd          (cmd_reg),
        .bad_flags    (bad_reg),
        .erased_flags (erased_reg),
        .dec          (dec),
        .tgt_blk      (tgt_blk),
        .mem_addr     (cmd_addr)
    );

    nbba_ram #(
        .WIDTH  (WL_BITS),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // The sweep owns the memory port; otherwise the decoded command address drives it.
    assign ram_we    = (state_reg == S_SWEEP) ||
                       ((state_reg == S_EXEC) && (dec.act == ACT_PROGRAM));
    assign ram_addr  = (state_reg == S_SWEEP) ? sweep_addr_reg : cmd_addr;
    assign ram_wdata = (state_reg == S_SWEEP) ? ERASED_WORD : cmd_reg.cell_values[WL_BITS-1:0];

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg;
        bad_next        = bad_reg;
        erased_next     = erased_reg;
        mask_next       = mask_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_last_next = sweep_last_reg;
        sweep_resp_next = sweep_resp_reg;

        if (cfg_valid && cfg_ready) begin
            mask_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_data;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_next.status       = dec.status;
                res_next.redirected   = dec.redirected;
                res_next.target_block = dec.target_block;
                res_next.read_data    = '0;
                state_next            = S_DONE;
                case (dec.act)
                    ACT_INIT: begin
                        erased_next     = '1;
                        bad_next        = NUM_BLOCKS'(mask_reg);
                        sweep_addr_next = '0;
                        sweep_last_next = ADDR_W'(DEPTH - 1);
                        sweep_resp_next = 1'b1;
                        state_next      = S_SWEEP;
                    end
                    ACT_ERASE: begin
                        erased_next[tgt_blk] = 1'b1;
                        sweep_addr_next      = ADDR_W'(tgt_blk * NUM_WORDLINES);
                        sweep_last_next      = ADDR_W'(tgt_blk * NUM_WORDLINES +
                                                       NUM_WORDLINES - 1);
                        sweep_resp_next      = 1'b1;
                        state_next           = S_SWEEP;
                    end
                    ACT_PROGRAM: begin
                        erased_next[tgt_blk] = 1'b0;
                    end
                    ACT_READ: begin
                        state_next = S_RDWAIT;
                    end
                    ACT_MARK: begin
                        bad_next[tgt_blk] = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_SWEEP: begin
                if (sweep_addr_reg == sweep_last_reg) begin
                    state_next = sweep_resp_reg ? S_DONE : S_IDLE;
                end else begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end
            S_RDWAIT: begin
                res_next.read_data = 32'(ram_rdata);
                state_next         = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // Reset starts with a clearing pass over the whole memory, with no result.
            state_reg      <= S_SWEEP;
            m_valid_reg    <= 1'b0;
            bad_reg        <= NUM_BLOCKS'(FACTORY_MASK_RESET);
            erased_reg     <= '1;
            mask_reg       <= FACTORY_MASK_RESET;
            sweep_addr_reg <= '0;
            sweep_last_reg <= ADDR_W'(DEPTH - 1);
            sweep_resp_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            bad_reg        <= bad_next;
            erased_reg     <= erased_next;
            mask_reg       <= mask_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
            sweep_resp_reg <= sweep_resp_next;
        end
        cmd_reg <= cmd_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

endmodule
